### design/date_add_days_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for date_add_days_top
// Concurrent assertion helpers, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DATE_ADD_DAYS_TOP_DEFINES_SVH
`define DATE_ADD_DAYS_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DAD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DAD_ASSERT_SAME(label, ante, cons, msg)
`define DAD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### design/dad_pkg.sv
// ----------------------------------------------------------------------------
// Date add days package
// Field widths, calendar tables, reciprocal constants and the command and
// status structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package dad_pkg;

  // Field widths.
  localparam int DEF_YEAR_BITS = 14;
  localparam int DAY_BITS      = 5;
  localparam int MONTH_BITS    = 4;
  localparam int CFG_BITS      = 12;
  localparam int N_BITS        = 13;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 12'd10;

  // Reciprocal of 25 scaled by 2^21; exact quotient for every 16-bit year.
  localparam int RECIP_BITS  = 17;
  localparam int RECIP_SHIFT = 21;
  localparam logic [RECIP_BITS-1:0] RECIP_25 = 17'd83887;

  // Calendar constants.
  localparam logic [MONTH_BITS-1:0] FEB_IDX        = 4'd1;
  localparam logic [MONTH_BITS-1:0] LAST_MONTH_IDX = 4'd11;
  localparam logic [MONTH_BITS-1:0] MONTH_MIN      = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_MAX      = 4'd12;
  localparam logic [8:0]            DAYS_COMMON    = 9'd365;
  localparam logic [8:0]            DAYS_LEAP      = 9'd366;
  localparam logic [DAY_BITS-1:0]   FEB_COMMON     = 5'd28;
  localparam logic [DAY_BITS-1:0]   FEB_LEAP       = 5'd29;

  typedef logic [DAY_BITS-1:0] month_len_t [12];
  typedef logic [8:0]          cum_days_t  [12];

  // Standard month lengths; the February entry is replaced per year.
  localparam month_len_t MONTH_LEN_ROM = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Days before the first of each month in a common year.
  localparam cum_days_t CUM_DAYS = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Month length for a zero-based month index, leap-aware.
  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] idx,
                                                    input logic leap);
    logic [DAY_BITS-1:0] len;
    if (idx == FEB_IDX) begin
      len = leap ? FEB_LEAP : FEB_COMMON;
    end else if (idx > LAST_MONTH_IDX) begin
      len = MONTH_LEN_ROM[LAST_MONTH_IDX];
    end else begin
      len = MONTH_LEN_ROM[idx];
    end
    return len;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic leap_mul;
    logic leap_eval;
    logic init;
    logic year_step;
    logic walk_start;
    logic walk_step;
    logic out_load;
  } dad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_fits;
    logic walk_done;
  } dad_status_t;

endpackage

### design/dad_stream_if.sv
// ----------------------------------------------------------------------------
// Date add days channel interfaces
// Valid/ready channels for the input date, the shifted date and the
// configuration write.
// ----------------------------------------------------------------------------

// Input date channel.
interface dad_in_if import dad_pkg::*; #(
  parameter int YEAR_BITS = DEF_YEAR_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [DAY_BITS-1:0]   in_day;
  logic [MONTH_BITS-1:0] in_month;
  logic [YEAR_BITS-1:0]  in_year;

  modport source (output valid, output in_day, output in_month, output in_year,
                  input ready);
  modport sink   (input valid, input in_day, input in_month, input in_year,
                  output ready);
endinterface

// Shifted date channel.
interface dad_out_if import dad_pkg::*; #(
  parameter int YEAR_BITS = DEF_YEAR_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [DAY_BITS-1:0]   out_day;
  logic [MONTH_BITS-1:0] out_month;
  logic [YEAR_BITS-1:0]  out_year;

  modport source (output valid, output out_day, output out_month, output out_year,
                  input ready);
  modport sink   (input valid, input out_day, input out_month, input out_year,
                  output ready);
endinterface

// Configuration write channel.
interface dad_cfg_if import dad_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] days_to_add;

  modport source (output valid, output days_to_add, input ready);
  modport sink   (input valid, input days_to_add, output ready);
endinterface

### design/dad_ctrl.sv
// ----------------------------------------------------------------------------
// Date add days controller
// Sequences the leap test, the year rollover loop, the month walk and the
// output register load for one request at a time.
// ----------------------------------------------------------------------------
module dad_ctrl import dad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  dad_status_t status,
  output dad_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAP_MUL,
    S_LEAP_EVAL,
    S_INIT,
    S_YEAR,
    S_WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          first_nxt = 1'b1;
          state_nxt = S_LEAP_MUL;
        end
      end
      S_LEAP_MUL: begin
        cmd.leap_mul = 1'b1;
        state_nxt    = S_LEAP_EVAL;
      end
      S_LEAP_EVAL: begin
        cmd.leap_eval = 1'b1;
        state_nxt     = first_r ? S_INIT : S_YEAR;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        first_nxt = 1'b0;
        state_nxt = S_YEAR;
      end
      S_YEAR: begin
        if (status.year_fits) begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WALK;
        end else begin
          cmd.year_step = 1'b1;
          state_nxt     = S_LEAP_MUL;
        end
      end
      S_WALK: begin
        if (!status.walk_done) begin
          cmd.walk_step = 1'b1;
        end else if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register stays full until the result is taken.
  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### design/dad_datapath.sv
// ----------------------------------------------------------------------------
// Date add days datapath
// Holds the working date, the day counter, the leap test and the output
// register, and steps them on commands from the controller.
// ----------------------------------------------------------------------------
module dad_datapath import dad_pkg::*; #(
  parameter int YEAR_BITS = DEF_YEAR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dad_cmd_t              cmd,
  input  logic [DAY_BITS-1:0]   in_day,
  input  logic [MONTH_BITS-1:0] in_month,
  input  logic [YEAR_BITS-1:0]  in_year,
  input  logic                  cfg_we,
  input  logic [CFG_BITS-1:0]   cfg_data,
  output dad_status_t           status,
  output logic [DAY_BITS-1:0]   out_day,
  output logic [MONTH_BITS-1:0] out_month,
  output logic [YEAR_BITS-1:0]  out_year
);

  localparam int PROD_BITS = YEAR_BITS + RECIP_BITS;

  logic [CFG_BITS-1:0]   days_to_add_r;
  logic [YEAR_BITS-1:0]  y_r, y_nxt;
  logic [N_BITS-1:0]     n_r, n_nxt;
  logic [DAY_BITS-1:0]   d_r, d_nxt;
  logic [MONTH_BITS-1:0] m_r, m_nxt;
  logic [MONTH_BITS-1:0] mi_r, mi_nxt;
  logic [PROD_BITS-1:0]  prod_r, prod_nxt;
  logic                  leap_r, leap_nxt;
  logic [DAY_BITS-1:0]   out_day_r, out_day_nxt;
  logic [MONTH_BITS-1:0] out_month_r, out_month_nxt;
  logic [YEAR_BITS-1:0]  out_year_r, out_year_nxt;

  logic [YEAR_BITS-1:0]  quot;
  logic [YEAR_BITS-1:0]  quot25;
  logic [YEAR_BITS-1:0]  rem25;
  logic [MONTH_BITS-1:0] m_idx;
  logic [DAY_BITS-1:0]   start_len;
  logic [DAY_BITS-1:0]   day_lo;
  logic [DAY_BITS-1:0]   day_clamped;
  logic                  leap_corr;
  logic [8:0]            year_len;
  logic [DAY_BITS-1:0]   walk_len;
  logic                  walk_done;

  // Leap test: divisible by 4, and not by 25 unless also by 16.
  assign quot   = YEAR_BITS'(prod_r[PROD_BITS-1:RECIP_SHIFT]);
  assign quot25 = (quot << 4) + (quot << 3) + quot;
  assign rem25  = y_r - quot25;

  // Start date: clamp the day to its month, then form the day of the year.
  assign m_idx       = m_r - MONTH_MIN;
  assign start_len   = month_len(m_idx, leap_r);
  assign day_lo      = (d_r == '0) ? DAY_BITS'(1) : d_r;
  assign day_clamped = (day_lo > start_len) ? start_len : day_lo;
  assign leap_corr   = leap_r && (m_idx > FEB_IDX);

  // Year rollover and month walk status.
  assign year_len  = leap_r ? DAYS_LEAP : DAYS_COMMON;
  assign walk_len  = month_len(mi_r, leap_r);
  assign walk_done = (mi_r == LAST_MONTH_IDX) || (n_r <= N_BITS'(walk_len));

  assign status.year_fits = (n_r <= N_BITS'(year_len));
  assign status.walk_done = walk_done;

  // Working register updates.
  always_comb begin
    y_nxt         = y_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    mi_nxt        = mi_r;
    prod_nxt      = prod_r;
    leap_nxt      = leap_r;
    out_day_nxt   = out_day_r;
    out_month_nxt = out_month_r;
    out_year_nxt  = out_year_r;
    if (cmd.load) begin
      y_nxt = in_year;
      d_nxt = in_day;
      if (in_month < MONTH_MIN) begin
        m_nxt = MONTH_MIN;
      end else if (in_month > MONTH_MAX) begin
        m_nxt = MONTH_MAX;
      end else begin
        m_nxt = in_month;
      end
    end
    if (cmd.leap_mul) begin
      prod_nxt = PROD_BITS'(y_r) * PROD_BITS'(RECIP_25);
    end
    if (cmd.leap_eval) begin
      leap_nxt = (y_r[1:0] == 2'b00) && ((rem25 != '0) || (y_r[3:0] == 4'b0000));
    end
    if (cmd.init) begin
      n_nxt = N_BITS'(day_clamped) + N_BITS'(CUM_DAYS[m_idx]) + N_BITS'(leap_corr)
            + N_BITS'(days_to_add_r);
    end
    if (cmd.year_step) begin
      n_nxt = n_r - N_BITS'(year_len);
      y_nxt = y_r + YEAR_BITS'(1);
    end
    if (cmd.walk_start) begin
      mi_nxt = '0;
    end
    if (cmd.walk_step) begin
      n_nxt  = n_r - N_BITS'(walk_len);
      mi_nxt = mi_r + MONTH_BITS'(1);
    end
    if (cmd.out_load) begin
      out_day_nxt   = n_r[DAY_BITS-1:0];
      out_month_nxt = mi_r + MONTH_BITS'(1);
      out_year_nxt  = y_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    y_r         <= y_nxt;
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    m_r         <= m_nxt;
    mi_r        <= mi_nxt;
    prod_r      <= prod_nxt;
    leap_r      <= leap_nxt;
    out_day_r   <= out_day_nxt;
    out_month_r <= out_month_nxt;
    out_year_r  <= out_year_nxt;
  end

  // Day offset register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      days_to_add_r <= CFG_RESET;
    end else if (cfg_we) begin
      days_to_add_r <= cfg_data;
    end
  end

  assign out_day   = out_day_r;
  assign out_month = out_month_r;
  assign out_year  = out_year_r;

endmodule

### design/date_add_days_top.sv
// ----------------------------------------------------------------------------
// Date add days top level
// Shifts each Gregorian input date forward by a programmable number of days.
// ----------------------------------------------------------------------------
// One request is worked at a time. After a request is accepted the block runs
// the leap test, forms the day count, rolls whole years over (at most 12 for
// the largest offset) and then walks the months of the final year before it
// loads the output register. The year rollover loop repeats the leap test for
// each year (a registered reciprocal multiply, then the remainder check), and
// the month walk retires one month per cycle.
// The finished date sits in an output register, so a new request is taken
// while the previous result waits. The next result then holds at the end of
// its walk until that register is free. The offset is written through the
// configuration channel, which is always ready, and resets to 10 days.
`include "date_add_days_top_defines.svh"

module date_add_days_top import dad_pkg::*; #(
  parameter int YEAR_BITS = DEF_YEAR_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  dad_in_if.sink    in_chan,
  dad_out_if.source out_chan,
  dad_cfg_if.sink   cfg_chan
);

  dad_cmd_t    cmd;
  dad_status_t status;

  // Configuration writes are taken in any cycle.
  assign cfg_chan.ready = 1'b1;

  // Controller.
  dad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  dad_datapath #(
    .YEAR_BITS (YEAR_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_day    (in_chan.in_day),
    .in_month  (in_chan.in_month),
    .in_year   (in_chan.in_year),
    .cfg_we    (cfg_chan.valid && cfg_chan.ready),
    .cfg_data  (cfg_chan.days_to_add),
    .status    (status),
    .out_day   (out_chan.out_day),
    .out_month (out_chan.out_month),
    .out_year  (out_chan.out_year)
  );

  // An accepted request keeps the input closed in the following cycle.
  `DAD_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready, "input ready after accept")

  // The output register is loaded only once the month walk has finished.
  `DAD_ASSERT_SAME(a_load_after_walk, cmd.out_load, status.walk_done, "output load before walk done")

  // A pending result is never overwritten.
  `DAD_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_chan.valid || out_chan.ready, "result overwritten")

  // A year is rolled over only when the day count exceeds it.
  `DAD_ASSERT_SAME(a_year_step_needed, cmd.year_step, !status.year_fits, "needless year step")

  // A delivered day of month is never zero.
  `DAD_ASSERT_SAME(a_day_nonzero, out_chan.valid, out_chan.out_day != '0, "day zero delivered")

endmodule

### tb/date_add_days_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for date_add_days_top
// Sends Gregorian dates through the input channel under a series of day
// offsets and checks every shifted date against a built-in calendar
// predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module date_add_days_top_test;
  import dad_pkg::*;

  localparam int          YEAR_BITS   = DEF_YEAR_BITS;
  localparam int unsigned YEAR_MASK   = (1 << YEAR_BITS) - 1;
  localparam int          N_PHASES    = 9;
  localparam int          RAND_PER_PH = 193;
  localparam int          SETTLE      = 64;
  localparam int          HOLD_CYCLES = 400;
  localparam int          CYCLE_LIMIT = 1000000;

  // Offsets per phase; the phases marked in pick_offset take a random one.
  localparam logic [CFG_BITS-1:0] PHASE_OFFSET [N_PHASES] = '{
    12'd10, 12'd0, 12'd4095, 12'd1, 12'd366, 12'd365, 12'd0, 12'd0, 12'd4094
  };

  typedef struct packed {
    logic [DAY_BITS-1:0]   day;
    logic [MONTH_BITS-1:0] month;
    logic [YEAR_BITS-1:0]  year;
  } date_t;

  // Stall patterns of the result sink.
  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_t;

  // Calendar predictor and store of expected shifted dates.
  class date_shift_board_t;
    logic [CFG_BITS-1:0] offset;
    date_t               shifted_q[$];
    int unsigned         checked;
    int unsigned         errors;

    function new();
      offset  = CFG_RESET;
      checked = 0;
      errors  = 0;
    endfunction

    function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Length of a zero-based month in the given year.
    function int unsigned days_in_month(int unsigned idx, int unsigned y);
      int unsigned lens [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (idx == 1) begin
        return is_leap(y) ? 29 : 28;
      end
      return lens[idx];
    endfunction

    function date_t shift_date(date_t req);
      int unsigned d, m, y, n, i, ml;
      date_t res;
      d = req.day;
      m = req.month;
      y = req.year;
      // Out-of-range months and days are clamped to the nearest legal value.
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      ml = days_in_month(m - 1, y);
      if (d < 1) d = 1;
      if (d > ml) d = ml;
      // Day of the year plus the offset.
      n = d;
      for (i = 0; i + 1 < m; i++) n += days_in_month(i, y);
      n += offset;
      // Roll whole years over; the year counter wraps at its width.
      while (n > (is_leap(y) ? 366 : 365)) begin
        n -= is_leap(y) ? 366 : 365;
        y = (y + 1) & YEAR_MASK;
      end
      // Walk the months of the final year.
      i = 0;
      while (i < 11 && n > days_in_month(i, y)) begin
        n -= days_in_month(i, y);
        i++;
      end
      res.day   = n[DAY_BITS-1:0];
      res.month = 4'(i + 1);
      res.year  = y[YEAR_BITS-1:0];
      return res;
    endfunction

    function void note_request(date_t req);
      shifted_q.push_back(shift_date(req));
    endfunction

    function void check_result(date_t got);
      date_t want;
      if (shifted_q.size() == 0) begin
        $display("%0t: result %0d/%0d/%0d with no request pending", $time,
                 got.day, got.month, got.year);
        errors++;
        return;
      end
      want = shifted_q.pop_front();
      checked++;
      if (got.day !== want.day) begin
        $display("%0t: out_day expected %0d, got %0d", $time, want.day, got.day);
        errors++;
      end
      if (got.month !== want.month) begin
        $display("%0t: out_month expected %0d, got %0d", $time, want.month, got.month);
        errors++;
      end
      if (got.year !== want.year) begin
        $display("%0t: out_year expected %0d, got %0d", $time, want.year, got.year);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_req;
  int   burst_left;
  int   cycle_count;

  date_shift_board_t board = new();

  dad_in_if  #(.YEAR_BITS(YEAR_BITS)) in_chan ();
  dad_out_if #(.YEAR_BITS(YEAR_BITS)) out_chan ();
  dad_cfg_if                          cfg_chan ();

  date_add_days_top #(.YEAR_BITS(YEAR_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               board.shifted_q.size());
      $display("date_add_days_top_test: errors");
      $finish;
    end
  end

  // Result sink: stretches of different stall patterns, plus one long hold-off
  // on demand while the sender keeps offering requests.
  initial begin : result_sink
    sink_mode_t mode;
    int         stretch_left;
    int         hold_left;
    int unsigned tick;
    out_chan.ready = 1'b0;
    mode         = SINK_OPEN;
    stretch_left = 0;
    hold_left    = 0;
    tick         = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          mode         = sink_mode_t'($urandom_range(0, 3));
          stretch_left = $urandom_range(16, 160);
        end
        stretch_left--;
        case (mode)
          SINK_OPEN:   out_chan.ready <= 1'b1;
          SINK_COIN:   out_chan.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_chan.ready <= ($urandom_range(0, 3) == 0);
          default:     out_chan.ready <= ((tick % 7) > 2);
        endcase
      end
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      board.check_result('{out_chan.out_day, out_chan.out_month, out_chan.out_year});
    end
  end

  // Hold the input channel idle for a number of cycles.
  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
  endtask

  // Offer one date request; bursts of random length are separated by random gaps, which may be empty.
  task automatic offer_date(input date_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) pause_sender(gap);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_chan.valid    <= 1'b1;
    in_chan.in_day   <= req.day;
    in_chan.in_month <= req.month;
    in_chan.in_year  <= req.year;
    do @(posedge clk); while (!in_chan.ready);
    board.note_request(req);
  endtask

  // Stop sending and wait until every pending request has produced its result.
  task automatic drain_results();
    pause_sender(1);
    while (board.shifted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the offset register while the block is idle.
  task automatic write_offset(input logic [CFG_BITS-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_chan.valid       <= 1'b1;
    cfg_chan.days_to_add <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    board.offset = value;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_offset(input int ph);
    if (ph == 6 || ph == 7) begin
      return CFG_BITS'($urandom_range(0, 4095));
    end
    return PHASE_OFFSET[ph];
  endfunction

  // Mostly legal dates, with leap boundaries, years near the top of the
  // counter, and raw field noise for the clamping rules.
  function automatic date_t random_date();
    date_t       r;
    int unsigned kind, y, m, ml;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      y = $urandom_range(1, 9999);
      m = $urandom_range(1, 12);
      r.day = DAY_BITS'($urandom_range(1, board.days_in_month(m - 1, y)));
    end else if (kind < 75) begin
      y = ($urandom_range(0, 1) == 1) ? 100 * $urandom_range(1, 99)
                                      : 4 * $urandom_range(1, 2499) + $urandom_range(0, 1);
      m = ($urandom_range(0, 1) == 1) ? 2 : 12;
      ml = board.days_in_month(m - 1, y);
      r.day = DAY_BITS'(ml - $urandom_range(0, 2));
    end else if (kind < 85) begin
      y = ($urandom_range(0, 1) == 1) ? $urandom_range(YEAR_MASK - 80, YEAR_MASK)
                                      : $urandom_range(9990, 10011);
      m = $urandom_range(1, 12);
      r.day = DAY_BITS'($urandom_range(1, board.days_in_month(m - 1, y)));
    end else begin
      y = $urandom_range(0, YEAR_MASK);
      m = $urandom_range(0, 15);
      r.day = DAY_BITS'($urandom_range(0, 31));
    end
    r.month = MONTH_BITS'(m);
    r.year  = YEAR_BITS'(y);
    return r;
  endfunction

  // Corner dates: range ends, leap days, century rules, clamping, year wrap.
  localparam date_t CORNER_DATES [16] = '{
    '{5'd1,  4'd1,  14'd1},
    '{5'd31, 4'd12, 14'd9999},
    '{5'd28, 4'd2,  14'd2023},
    '{5'd29, 4'd2,  14'd2024},
    '{5'd30, 4'd2,  14'd2023},
    '{5'd29, 4'd2,  14'd1900},
    '{5'd29, 4'd2,  14'd2000},
    '{5'd0,  4'd0,  14'd0},
    '{5'd31, 4'd15, 14'd16383},
    '{5'd25, 4'd12, 14'd16383},
    '{5'd15, 4'd13, 14'd2000},
    '{5'd31, 4'd4,  14'd2021},
    '{5'd31, 4'd6,  14'd400},
    '{5'd21, 4'd12, 14'd100},
    '{5'd22, 4'd12, 14'd2099},
    '{5'd1,  4'd3,  14'd2100}
  };

  // Stimulus: reset, corner dates, then random requests per offset setting.
  initial begin : stimulus
    int ph;
    int k;
    rst_n                = 1'b0;
    hold_req             = 1'b0;
    burst_left           = 0;
    cycle_count          = 0;
    in_chan.valid        = 1'b0;
    in_chan.in_day       = '0;
    in_chan.in_month     = '0;
    in_chan.in_year      = '0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.days_to_add = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) write_offset(pick_offset(ph));
      if (ph == 0) begin
        foreach (CORNER_DATES[i]) offer_date(CORNER_DATES[i]);
      end
      for (k = 0; k < RAND_PER_PH; k++) begin
        // Long sink hold-off: the block fills up and stalls its input.
        if (ph == 2 && k == 30) hold_req = 1'b1;
        // Sender pause until every result is back.
        if (ph == 4 && k == 100) drain_results();
        offer_date(random_date());
      end
    end

    drain_results();
    $display("Checked %0d shifted dates across %0d offset settings, including", board.checked,
             N_PHASES);
    $display("clamped days and months, leap boundaries and year counter wrap.");
    if (board.errors == 0) begin
      $display("date_add_days_top_test: clean");
    end else begin
      $display("date_add_days_top_test: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/dad_pkg.sv
design/dad_stream_if.sv
design/dad_ctrl.sv
design/dad_datapath.sv
design/date_add_days_top.sv
tb/date_add_days_top_test.sv
